// ===== hw/rtl/clb_pkg.sv =====
// Shared constants, types and the byte classifier of the circular log buffer.
`timescale 1ns / 1ps

package clb_pkg;

    localparam int unsigned DEPTH  = 4096;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned SIZE_W = 13;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);

    localparam logic [7:0] MARK_LO    = 8'h10;
    localparam logic [7:0] MARK_HI    = 8'h18;
    localparam logic [7:0] SUBST_CHAR = 8'h3F;
    localparam logic [7:0] PRINT_LO   = 8'h20;
    localparam logic [7:0] PRINT_HI   = 8'h7E;
    localparam logic [7:0] SPACE_LO   = 8'h09;
    localparam logic [7:0] SPACE_HI   = 8'h0D;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PASS  = 2'd1,
        KIND_SUBST = 2'd2,
        KIND_DROP  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] out_char;
        kind_t      kind;
    } char_res_t;

    function automatic char_res_t classify(input logic [7:0] b);
        char_res_t r;
        if (b >= MARK_LO && b <= MARK_HI) begin
            r.out_char = 8'd0;
            r.kind     = KIND_DROP;
        end else if ((b >= PRINT_LO && b <= PRINT_HI) || (b >= SPACE_LO && b <= SPACE_HI)) begin
            r.out_char = b;
            r.kind     = KIND_PASS;
        end else begin
            r.out_char = SUBST_CHAR;
            r.kind     = KIND_SUBST;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/clb_log_ram.sv =====
// Single-port byte store with a registered read, one access per cycle.
`timescale 1ns / 1ps

module clb_log_ram #(
    parameter int unsigned ADDR_W = 12,
    parameter int unsigned DATA_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/circular_log_buffer_unit.sv =====
// Top level of the circular log buffer: pointers, snapshot readout and result register.
`timescale 1ns / 1ps

// Console log ring buffer. Write beats store one byte each into a 4096-byte store and
// wrap at log_size, setting a sticky overflow flag; a start beat latches a snapshot
// from the oldest byte, and read beats return it in order, sanitized. Every beat gives
// exactly one result beat. Write, start and unused beats, and a read beat that finds
// nothing remaining, load the result register directly; a read beat returning a byte
// loads it from the registered store data, accepting no new beat meanwhile. A new beat
// is taken in the cycle its predecessor's result is consumed. The user must write
// log_size on cfg_we only while the block is idle; the block does not enforce it. 0 acts
// as 1, values above 4096 act as 4096. The store has no reset and needs no clearing pass.
module circular_log_buffer_unit
    import clb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] write_byte
    input  logic        s_tlast,   // last_in_call
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_char, [8] read_empty, [9] overflowed,
                                   // [22:10] used_bytes, [23] zero
    output logic        m_tlast,   // read_last
    output logic [1:0]  m_tuser    // [1:0] char_kind
);

    typedef struct packed {
        logic              last;
        logic              ovf;
        logic [SIZE_W-1:0] used;
    } pend_t;

    logic [SIZE_W-1:0] log_size_reg;
    logic [ADDR_W-1:0] wr_pos_reg, wr_pos_next;
    logic              wrap_reg, wrap_next;
    logic [ADDR_W-1:0] rd_pos_reg, rd_pos_next;
    logic [SIZE_W-1:0] rd_rem_reg, rd_rem_next;

    logic              pend_valid_reg;
    pend_t             pend_reg, pend_next;

    logic              m_valid_reg;
    logic [7:0]        o_char_reg, o_char_next;
    kind_t             o_kind_reg, o_kind_next;
    logic              o_last_reg, o_last_next;
    logic              o_empty_reg, o_empty_next;
    logic              o_ovf_reg, o_ovf_next;
    logic [SIZE_W-1:0] o_used_reg, o_used_next;

    logic              accept;
    action_t           act;
    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W-1:0] used_cur, used_next;
    logic [SIZE_W-1:0] wr_inc, rd_inc;
    logic              load_direct;
    logic              issue_read;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_rdata;
    char_res_t         cls;

    assign act      = action_t'(s_tuser);
    assign s_tready = !pend_valid_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        if (log_size_reg == '0) begin
            eff_size = SIZE_W'(1);
        end else if (log_size_reg > SIZE_MAX) begin
            eff_size = SIZE_MAX;
        end else begin
            eff_size = log_size_reg;
        end
    end

    assign wr_inc = SIZE_W'(wr_pos_reg) + SIZE_W'(1);
    assign rd_inc = SIZE_W'(rd_pos_reg) + SIZE_W'(1);

    assign used_cur = wrap_reg ? eff_size :
                      ((SIZE_W'(wr_pos_reg) < eff_size) ? SIZE_W'(wr_pos_reg) : eff_size);

    always_comb begin
        wr_pos_next  = wr_pos_reg;
        wrap_next    = wrap_reg;
        rd_pos_next  = rd_pos_reg;
        rd_rem_next  = rd_rem_reg;
        o_empty_next = 1'b0;
        o_last_next  = 1'b0;
        issue_read   = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = wr_pos_reg;
        if (accept) begin
            unique case (act)
                ACT_WRITE: begin
                    ram_we = 1'b1;
                    if (wr_inc >= eff_size) begin
                        wr_pos_next = '0;
                        wrap_next   = 1'b1;
                    end else begin
                        wr_pos_next = wr_inc[ADDR_W-1:0];
                    end
                end
                ACT_START: begin
                    rd_pos_next = (wrap_reg && SIZE_W'(wr_pos_reg) < eff_size) ? wr_pos_reg : '0;
                    rd_rem_next = used_cur;
                end
                ACT_READ: begin
                    if (rd_rem_reg == '0) begin
                        o_empty_next = 1'b1;
                    end else begin
                        issue_read  = 1'b1;
                        ram_addr    = rd_pos_reg;
                        rd_pos_next = (rd_inc >= eff_size) ? '0 : rd_inc[ADDR_W-1:0];
                        rd_rem_next = rd_rem_reg - SIZE_W'(1);
                        o_last_next = (rd_rem_next == '0);
                    end
                end
                ACT_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign used_next = wrap_next ? eff_size :
                       ((SIZE_W'(wr_pos_next) < eff_size) ? SIZE_W'(wr_pos_next) : eff_size);

    assign pend_next.last = o_last_next;
    assign pend_next.ovf  = wrap_next;
    assign pend_next.used = used_next;

    assign load_direct = accept && !issue_read;
    assign cls         = classify(ram_rdata);

    // A read beat finishes in the cycle after it is accepted, when the store data arrives.
    always_comb begin
        o_char_next = 8'd0;
        o_kind_next = KIND_NONE;
        o_ovf_next  = wrap_next;
        o_used_next = used_next;
        if (pend_valid_reg) begin
            o_char_next = cls.out_char;
            o_kind_next = cls.kind;
            o_ovf_next  = pend_reg.ovf;
            o_used_next = pend_reg.used;
        end
    end

    clb_log_ram #(
        .ADDR_W(ADDR_W),
        .DATA_W(8)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .re   (issue_read),
        .addr (ram_addr),
        .wdata(s_tdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_size_reg   <= SIZE_RESET;
            wr_pos_reg     <= '0;
            wrap_reg       <= 1'b0;
            rd_pos_reg     <= '0;
            rd_rem_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                log_size_reg <= cfg_wdata;
            end
            wr_pos_reg     <= wr_pos_next;
            wrap_reg       <= wrap_next;
            rd_pos_reg     <= rd_pos_next;
            rd_rem_reg     <= rd_rem_next;
            pend_valid_reg <= issue_read;
            if (load_direct || pend_valid_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue_read) begin
            pend_reg <= pend_next;
        end
        if (load_direct || pend_valid_reg) begin
            o_char_reg  <= o_char_next;
            o_kind_reg  <= o_kind_next;
            o_last_reg  <= pend_valid_reg ? pend_reg.last : 1'b0;
            o_empty_reg <= pend_valid_reg ? 1'b0 : o_empty_next;
            o_ovf_reg   <= o_ovf_next;
            o_used_reg  <= o_used_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, o_used_reg, o_ovf_reg, o_empty_reg, o_char_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = o_kind_reg;

endmodule
